// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tfs_pkg.sv =====
// ---------------------------------------------------------------------------
// tfs_pkg: shared types and codes of the tracker failover scheduler
// Request and result payload structs, event and timer codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfs_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_seconds;
        logic [1:0]  result_kind;
        logic [23:0] reply_interval;
    } t_req;

    typedef struct packed {
        logic        cancel_pending;
        logic        send_now;
        logic [2:0]  target_slot;
        logic [1:0]  event_code;
        logic [1:0]  timer_action;
        logic [1:0]  timer_class;
        logic [23:0] timer_seconds;
        logic        tier_live;
        logic        tier_good;
    } t_res;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_STOP     = 3'd1;
    localparam logic [2:0] MODE_COMPLETE = 3'd2;
    localparam logic [2:0] MODE_RESPONSE = 3'd3;
    localparam logic [2:0] MODE_TIMER    = 3'd4;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_STARTED   = 2'd1;
    localparam logic [1:0] EV_STOPPED   = 2'd2;
    localparam logic [1:0] EV_COMPLETED = 2'd3;

    localparam logic [1:0] TA_LEAVE  = 2'd0;
    localparam logic [1:0] TA_DISARM = 2'd1;
    localparam logic [1:0] TA_ARM    = 2'd2;

    localparam logic [1:0] TC_EXACT  = 2'd0;
    localparam logic [1:0] TC_DEFLT  = 2'd1;
    localparam logic [1:0] TC_RETRY1 = 2'd2;
    localparam logic [1:0] TC_RETRY2 = 2'd3;

    localparam logic [1:0] RK_SRV_FAIL  = 2'd0;
    localparam logic [1:0] RK_CONN_FAIL = 2'd1;
    localparam logic [1:0] RK_BAD_DATA  = 2'd2;
    localparam logic [1:0] RK_OK        = 2'd3;

    localparam logic [2:0] RA_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] RA_MIN_GAP     = 3'd4;

endpackage

// ===== hw/rtl/tracker_failover_scheduler.sv =====
// Tracker failover scheduler. One request (start, stop, complete, response,
// timer expiry) yields one result: cancel, send to a server slot with an
// event code, and a timer action. A small sequencer walks the slot list one
// position per cycle with a single shared scan/compare step (finding the first
// non-failed server, or rotating a responding server to the front); a request
// that may send then passes the request-spacing check (one subtract and compare)
// in S_ISSUE before the result is held for the consumer in S_OUT. An ignored
// request goes straight to the held result, a direct send passes through
// S_ISSUE, a response that moves a server to the front passes through S_ROT,
// and a server failure first scans to confirm a good server and then scans
// past the current one. The block takes no new request until the result is
// taken.
// ---------------------------------------------------------------------------
// tracker_failover_scheduler: announce tier failover and retry control
// Sequenced scan over the slot list with a shared compare/shift step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tracker_failover_scheduler
    import tfs_pkg::*;
#(
    parameter int MAX_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // find first good from r_scan
    localparam logic [2:0] S_ROT   = 3'd2;  // move responder to front
    localparam logic [2:0] S_ISSUE = 3'd3;  // spacing check / send
    localparam logic [2:0] S_OUT   = 3'd4;

    // scan purposes
    localparam logic [1:0] P_ANYGOOD = 2'd0; // response server fail: any good?
    localparam logic [1:0] P_NEXT    = 2'd1; // next after current position
    localparam logic [1:0] P_FIRST   = 2'd2; // first good, else position 0
    localparam logic [1:0] P_TIMER   = 2'd3; // first good, ignore if none

    logic [2:0]           r_state;
    logic [1:0]           r_purp;
    logic [CW-1:0]        r_scan;
    logic [SW-1:0]        r_order [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_failed;
    logic [SW-1:0]        r_cur;
    logic [1:0]           r_event;
    logic                 r_active, r_responded, r_pending;
    logic [7:0]           r_bad;
    logic [23:0]          r_learned;
    logic [TIME_BITS-1:0] r_last, r_next, r_now;
    logic [3:0]           r_entry_cnt, r_gap;
    logic [SW-1:0]        r_ipos;
    logic [1:0]           r_iev;
    logic [SW-1:0]        r_hold;
    t_res                 r_res;

    // effective list length
    logic [CW-1:0] total;
    always_comb begin
        if (r_entry_cnt == 4'd0)
            total = CW'(1);
        else if (32'(r_entry_cnt) > MAX_SLOTS)
            total = CW'(MAX_SLOTS);
        else
            total = CW'(r_entry_cnt);
    end

    logic [SW-1:0] cur_p;
    assign cur_p = (CW'(r_cur) < total) ? r_cur : '0;

    logic scan_idx_ok;
    logic scan_hit;
    assign scan_idx_ok = r_scan < total;
    assign scan_hit = scan_idx_ok && !r_failed[r_order[r_scan[SW-1:0]]];

    // spacing check
    logic [TIME_BITS-1:0] elapsed, base, nxt, dly;
    logic                 too_early;
    always_comb begin
        elapsed = r_now - r_last;
        too_early = (r_last > r_now) || (elapsed < TIME_BITS'(r_gap));
        base = (r_next > r_last) ? r_next : r_last;
        nxt = base + TIME_BITS'(r_gap);
        dly = nxt - r_now;
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr)
            RA_ENTRY_COUNT: prdata = {28'd0, r_entry_cnt};
            RA_MIN_GAP:     prdata = {28'd0, r_gap};
            default:        prdata = '0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    logic acc;
    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_purp <= P_ANYGOOD;
            r_scan <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) r_order[i] <= SW'(i);
            r_failed <= '0;
            r_cur <= '0;
            r_event <= EV_STOPPED;
            r_active <= 1'b0;
            r_responded <= 1'b0;
            r_pending <= 1'b0;
            r_bad <= '0;
            r_learned <= '0;
            r_last <= '0;
            r_next <= '0;
            r_entry_cnt <= 4'd1;
            r_gap <= 4'd1;
            r_now <= '0;
            r_ipos <= '0;
            r_iev <= EV_NONE;
            r_hold <= '0;
            r_res <= '0;
        end else begin
            if (cfg_wr && paddr == RA_ENTRY_COUNT) begin
                r_entry_cnt <= pwdata[3:0];
                for (int i = 0; i < MAX_SLOTS; i++) r_order[i] <= SW'(i);
                r_failed <= '0;
                r_cur <= '0;
            end
            if (cfg_wr && paddr == RA_MIN_GAP) r_gap <= pwdata[3:0];

            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_now <= TIME_BITS'(i_req.now_seconds);
                        r_res <= '0;
                        r_state <= S_OUT;
                        case (i_req.mode)
                            MODE_START: begin
                                r_failed <= '0;
                                r_responded <= 1'b0;
                                r_bad <= '0;
                                r_active <= 1'b1;
                                r_ipos <= '0;
                                r_iev <= EV_STARTED;
                                r_state <= S_ISSUE;
                            end
                            MODE_STOP: begin
                                if (r_active && r_event != EV_STOPPED) begin
                                    if (!r_responded && r_bad > 8'd1) begin
                                        r_res.timer_action <= TA_DISARM;
                                        r_res.cancel_pending <= r_pending;
                                        r_pending <= 1'b0;
                                        r_active <= 1'b0;
                                    end else begin
                                        r_iev <= EV_STOPPED;
                                        r_purp <= P_FIRST;
                                        r_scan <= '0;
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            MODE_COMPLETE: begin
                                if (r_active && r_event == EV_NONE) begin
                                    r_ipos <= '0;
                                    r_iev <= EV_COMPLETED;
                                    r_state <= S_ISSUE;
                                end
                            end
                            MODE_RESPONSE: begin
                                if (r_pending) begin
                                    r_pending <= 1'b0;
                                    r_iev <= r_event;
                                    if (i_req.result_kind == RK_SRV_FAIL) begin
                                        r_failed[r_order[cur_p]] <= 1'b1;
                                        r_purp <= P_ANYGOOD;
                                        r_scan <= '0;
                                        r_state <= S_SCAN;
                                    end else if (i_req.result_kind == RK_CONN_FAIL) begin
                                        r_purp <= P_NEXT;
                                        r_scan <= CW'(cur_p) + CW'(1);
                                        r_state <= S_SCAN;
                                    end else begin
                                        if (r_event == EV_STOPPED) begin
                                            r_active <= 1'b0;
                                        end else begin
                                            r_event <= EV_NONE;
                                            r_res.timer_action <= TA_ARM;
                                            if (i_req.reply_interval != 24'd0) begin
                                                r_learned <= i_req.reply_interval;
                                                r_res.timer_seconds <= i_req.reply_interval;
                                            end else if (r_learned != 24'd0) begin
                                                r_res.timer_seconds <= r_learned;
                                            end else begin
                                                r_res.timer_class <= TC_DEFLT;
                                            end
                                        end
                                        r_bad <= '0;
                                        r_responded <= 1'b1;
                                        r_hold <= r_order[cur_p];
                                        r_scan <= CW'(cur_p);
                                        r_cur <= '0;
                                        r_state <= S_ROT;
                                    end
                                end
                            end
                            MODE_TIMER: begin
                                if (r_active) begin
                                    r_iev <= r_event;
                                    r_purp <= P_TIMER;
                                    r_scan <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        if (r_purp == P_ANYGOOD) begin
                            r_purp <= P_NEXT;
                            r_scan <= CW'(cur_p) + CW'(1);
                        end else begin
                            r_ipos <= r_scan[SW-1:0];
                            r_state <= S_ISSUE;
                        end
                    end else if (!scan_idx_ok) begin
                        case (r_purp)
                            P_ANYGOOD: begin
                                r_active <= 1'b0;
                                r_state <= S_OUT;
                            end
                            P_FIRST: begin
                                r_ipos <= '0;
                                r_state <= S_ISSUE;
                            end
                            P_TIMER: r_state <= S_OUT;
                            default: begin
                                // no server left after current: count it
                                r_state <= S_OUT;
                                if (r_bad != 8'hFF) r_bad <= r_bad + 8'd1;
                                if (r_event == EV_STOPPED && r_bad >= 8'd1) begin
                                    r_active <= 1'b0;
                                end else if (r_bad == 8'd0) begin
                                    r_ipos <= '0;
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_res.timer_action <= TA_ARM;
                                    r_res.timer_class <= (r_bad == 8'd1) ? TC_RETRY1
                                                                         : TC_RETRY2;
                                end
                            end
                        endcase
                    end else begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                S_ROT: begin
                    // shift one position per cycle toward the back
                    if (r_scan == '0) begin
                        r_order[0] <= r_hold;
                        r_state <= S_OUT;
                    end else begin
                        r_order[r_scan[SW-1:0]] <= r_order[r_scan[SW-1:0] - SW'(1)];
                        r_scan <= r_scan - CW'(1);
                    end
                end
                S_ISSUE: begin
                    r_res.cancel_pending <= r_pending;
                    r_pending <= 1'b0;
                    r_event <= r_iev;
                    r_cur <= r_ipos;
                    r_state <= S_OUT;
                    if (too_early) begin
                        r_next <= nxt;
                        r_res.timer_action <= TA_ARM;
                        r_res.timer_class <= TC_EXACT;
                        r_res.timer_seconds <= (dly > TIME_BITS'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                       : 24'(dly);
                    end else begin
                        r_res.timer_action <= TA_DISARM;
                        r_res.send_now <= 1'b1;
                        r_res.target_slot <= 3'(r_order[r_ipos]);
                        r_res.event_code <= r_iev;
                        r_pending <= 1'b1;
                        r_last <= r_now;
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // status fields come straight from the tier state, which is final and
    // held steady while the result waits in S_OUT
    logic out_active, out_good;
    assign out_active = r_active;
    assign out_good = r_active && (r_bad == 8'd0);

    always_comb begin
        o_res = r_res;
        o_res.tier_live = out_active;
        o_res.tier_good = out_good;
    end

    `ASSERT_IMPL(a_out_only_done, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `ASSERT_IMPL(a_send_has_pend, i_clk, i_rst_n, o_valid && r_res.send_now, r_pending)
    `ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, acc, o_stall)

endmodule
